/* rtl/hsl2rgb_pkg.sv */
// ----------------------------------------------------------------------------
// HSL to RGB package
// Constants, hue sector routing and channel scaling shared by the converter.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

    // Field widths
    localparam int HUE_W  = 15;
    localparam int FRAC_W = 17;
    localparam int CHAN_W = 8;

    // Derived widths
    localparam int SECT_W = 4;               // hue sectors 0..8 for any 15-bit hue
    localparam int POS_W  = 12;              // position inside a sector, 0..3840
    localparam int AS_W   = 2 * FRAC_W - 1;  // a * s, up to 2^32
    localparam int XAS_W  = AS_W + POS_W;    // a * s * q
    localparam int SUM_W  = 2 * FRAC_W;      // l * 2^17 plus or minus a * s
    localparam int NUM_W  = 46;              // channel numerators
    localparam int SCL_W  = NUM_W + 5;       // numerator times 17
    localparam int SHR    = 41;              // 255 / (2^33 * 3840) == 17 / 2^41

    // Constants
    localparam logic [FRAC_W-1:0] ONE_Q16      = 17'd65536;
    localparam logic [HUE_W-1:0]  SECTOR_UNITS = 15'd3840;
    localparam int                LAST_SECTOR  = 8;

    // What a channel carries
    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_C,
        SEL_X
    } comp_sel_t;

    typedef struct packed {
        comp_sel_t red;
        comp_sel_t green;
        comp_sel_t blue;
    } sector_route_t;

    // Component order for each hue sector; sector 5 and above share one order
    function automatic sector_route_t sector_route(input logic [SECT_W-1:0] sector);
        sector_route_t r;
        case (sector)
            4'd0:    r = '{red: SEL_C,    green: SEL_X,    blue: SEL_ZERO};
            4'd1:    r = '{red: SEL_X,    green: SEL_C,    blue: SEL_ZERO};
            4'd2:    r = '{red: SEL_ZERO, green: SEL_C,    blue: SEL_X};
            4'd3:    r = '{red: SEL_ZERO, green: SEL_X,    blue: SEL_C};
            4'd4:    r = '{red: SEL_X,    green: SEL_ZERO, blue: SEL_C};
            default: r = '{red: SEL_C,    green: SEL_ZERO, blue: SEL_X};
        endcase
        return r;
    endfunction

    // floor(n * 17 / 2^41), clamped to a byte
    function automatic logic [CHAN_W-1:0] chan_scale(input logic [NUM_W-1:0] n);
        logic [SCL_W-1:0]   t;
        logic [SCL_W-SHR-1:0] v;
        t = {1'b0, n, 4'b0000} + {5'b00000, n};
        v = t[SCL_W-1:SHR];
        if (v > {{(SCL_W-SHR-CHAN_W){1'b0}}, {CHAN_W{1'b1}}}) begin
            return {CHAN_W{1'b1}};
        end
        return v[CHAN_W-1:0];
    endfunction

    // Pick the numerator for one channel
    function automatic logic [NUM_W-1:0] chan_pick(input comp_sel_t sel,
                                                   input logic [NUM_W-1:0] nc,
                                                   input logic [NUM_W-1:0] nx,
                                                   input logic [NUM_W-1:0] n0);
        logic [NUM_W-1:0] r;
        case (sel)
            SEL_C:   r = nc;
            SEL_X:   r = nx;
            default: r = n0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/hsl_to_rgb_color_convert.sv */
// ----------------------------------------------------------------------------
// HSL to RGB colour converter
// Five-stage pipeline converting one HSL colour per transaction to 8-bit RGB.
// ----------------------------------------------------------------------------
// Takes one colour every clock cycle while the result side accepts, and
// delivers its RGB bytes through stage registers 1 to 4 plus the output
// register; the pipeline's deepest steps are the 17x17 a*s product in
// stage 2 and the 33x12 product against the in-sector position in stage 3.
// Hue is in 1/64 degree; saturation and lightness are Q1.16 with 65536 as 1.0
// and anything larger is treated as 1.0. A hue at or above 360 degrees keeps
// the last sector's channel order. Backpressure on the result side stalls the
// pipeline in place; empty stages still fill while the output waits.
module hsl_to_rgb_color_convert (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [hsl2rgb_pkg::HUE_W-1:0]     s_hue,
    input  logic [hsl2rgb_pkg::FRAC_W-1:0]    s_saturation,
    input  logic [hsl2rgb_pkg::FRAC_W-1:0]    s_lightness,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [hsl2rgb_pkg::CHAN_W-1:0]    m_red,
    output logic [hsl2rgb_pkg::CHAN_W-1:0]    m_green,
    output logic [hsl2rgb_pkg::CHAN_W-1:0]    m_blue
);
    import hsl2rgb_pkg::*;

    // Stage registers
    logic                 st1_valid_reg, st2_valid_reg, st3_valid_reg, st4_valid_reg;
    logic                 m_valid_reg;
    logic [SECT_W-1:0]    st1_sector_reg, st2_sector_reg, st3_sector_reg, st4_sector_reg;
    logic [POS_W-1:0]     st1_q_reg, st2_q_reg;
    logic [FRAC_W-1:0]    st1_a_reg, st1_s_reg, st1_l_reg, st2_l_reg;
    logic [AS_W-1:0]      st2_as_reg;
    logic [XAS_W-1:0]     st3_xas_reg;
    logic [SUM_W-1:0]     st3_p_reg, st3_m_reg;
    logic [NUM_W-1:0]     st4_nc_reg, st4_nx_reg, st4_n0_reg;
    logic [CHAN_W-1:0]    m_red_reg, m_green_reg, m_blue_reg;

    // Next values
    logic [SECT_W-1:0]    st1_sector_next;
    logic [POS_W-1:0]     st1_q_next;
    logic [FRAC_W-1:0]    st1_a_next, st1_s_next, st1_l_next;
    logic [AS_W-1:0]      st2_as_next;
    logic [XAS_W-1:0]     st3_xas_next;
    logic [SUM_W-1:0]     st3_p_next, st3_m_next;
    logic [NUM_W-1:0]     st4_nc_next, st4_nx_next, st4_n0_next;
    logic [CHAN_W-1:0]    m_red_next, m_green_next, m_blue_next;

    logic                 st1_ready, st2_ready, st3_ready, st4_ready, out_ready;

    // Ready chain: a stage moves when it is empty or its successor moves
    assign out_ready = !m_valid_reg   || m_ready;
    assign st4_ready = !st4_valid_reg || out_ready;
    assign st3_ready = !st3_valid_reg || st4_ready;
    assign st2_ready = !st2_valid_reg || st3_ready;
    assign st1_ready = !st1_valid_reg || st2_ready;
    assign s_ready   = st1_ready;

    // Stage 1: saturate, find hue sector, fold position, form 1 - |2L - 1|
    always_comb begin
        logic [HUE_W-1:0]  base;
        logic [HUE_W-1:0]  pos;
        logic [FRAC_W:0]   twol;
        logic [FRAC_W:0]   lum_dev;
        logic [FRAC_W:0]   a_wide;
        st1_s_next = (s_saturation > ONE_Q16) ? ONE_Q16 : s_saturation;
        st1_l_next = (s_lightness  > ONE_Q16) ? ONE_Q16 : s_lightness;

        st1_sector_next = '0;
        base            = '0;
        for (int k = 1; k <= LAST_SECTOR; k++) begin
            if (s_hue >= HUE_W'(k * int'(SECTOR_UNITS))) begin
                st1_sector_next = SECT_W'(k);
                base            = HUE_W'(k * int'(SECTOR_UNITS));
            end
        end
        pos = s_hue - base;
        if (st1_sector_next[0]) begin
            st1_q_next = POS_W'(SECTOR_UNITS - pos);
        end else begin
            st1_q_next = pos[POS_W-1:0];
        end

        twol = {st1_l_next, 1'b0};
        if (twol >= {1'b0, ONE_Q16}) begin
            lum_dev = twol - {1'b0, ONE_Q16};
        end else begin
            lum_dev = {1'b0, ONE_Q16} - twol;
        end
        a_wide     = {1'b0, ONE_Q16} - lum_dev;
        st1_a_next = a_wide[FRAC_W-1:0];
    end

    // Stage 2: chroma product a * s (chroma scaled by 2^32)
    assign st2_as_next = AS_W'(st1_a_reg * st1_s_reg);

    // Stage 3: second-component product, lightness sum and offset
    assign st3_xas_next = XAS_W'(st2_as_reg * st2_q_reg);
    assign st3_p_next   = {st2_l_reg, {FRAC_W{1'b0}}} + {1'b0, st2_as_reg};
    assign st3_m_next   = {st2_l_reg, {FRAC_W{1'b0}}} - {1'b0, st2_as_reg};

    // Stage 4: numerators, scaled by 3840 as shift and subtract
    always_comb begin
        st4_nc_next = {st3_p_reg, 12'd0} - {4'd0, st3_p_reg, 8'd0};
        st4_n0_next = NUM_W'({st3_m_reg, 12'd0} - {4'd0, st3_m_reg, 8'd0});
        st4_nx_next = {st3_xas_reg, 1'b0} + st4_n0_next;
    end

    // Stage 5: route components to channels and scale to bytes
    always_comb begin
        sector_route_t route;
        route       = sector_route(st4_sector_reg);
        m_red_next   = chan_scale(chan_pick(route.red,   st4_nc_reg, st4_nx_reg, st4_n0_reg));
        m_green_next = chan_scale(chan_pick(route.green, st4_nc_reg, st4_nx_reg, st4_n0_reg));
        m_blue_next  = chan_scale(chan_pick(route.blue,  st4_nc_reg, st4_nx_reg, st4_n0_reg));
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            st4_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (st1_ready) st1_valid_reg <= s_valid;
            if (st2_ready) st2_valid_reg <= st1_valid_reg;
            if (st3_ready) st3_valid_reg <= st2_valid_reg;
            if (st4_ready) st4_valid_reg <= st3_valid_reg;
            if (out_ready) m_valid_reg   <= st4_valid_reg;
        end
    end

    // Payload registers, loaded only when a transaction moves in
    always_ff @(posedge aclk) begin
        if (st1_ready && s_valid) begin
            st1_sector_reg <= st1_sector_next;
            st1_q_reg      <= st1_q_next;
            st1_a_reg      <= st1_a_next;
            st1_s_reg      <= st1_s_next;
            st1_l_reg      <= st1_l_next;
        end
        if (st2_ready && st1_valid_reg) begin
            st2_sector_reg <= st1_sector_reg;
            st2_q_reg      <= st1_q_reg;
            st2_l_reg      <= st1_l_reg;
            st2_as_reg     <= st2_as_next;
        end
        if (st3_ready && st2_valid_reg) begin
            st3_sector_reg <= st2_sector_reg;
            st3_xas_reg    <= st3_xas_next;
            st3_p_reg      <= st3_p_next;
            st3_m_reg      <= st3_m_next;
        end
        if (st4_ready && st3_valid_reg) begin
            st4_sector_reg <= st3_sector_reg;
            st4_nc_reg     <= st4_nc_next;
            st4_nx_reg     <= st4_nx_next;
            st4_n0_reg     <= st4_n0_next;
        end
        if (out_ready && st4_valid_reg) begin
            m_red_reg   <= m_red_next;
            m_green_reg <= m_green_next;
            m_blue_reg  <= m_blue_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_red   = m_red_reg;
    assign m_green = m_green_reg;
    assign m_blue  = m_blue_reg;

    // Checks
    a_accept_fills_st1: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> st1_valid_reg)
        else $error("accepted transaction did not reach stage 1");

    a_st4_holds_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        st4_valid_reg && !st4_ready |=> st4_valid_reg && $stable(st4_nc_reg)
            && $stable(st4_nx_reg) && $stable(st4_sector_reg))
        else $error("stage 4 lost or changed a stalled transaction");

    a_st3_to_st4: assert property (@(posedge aclk) disable iff (!aresetn)
        st3_valid_reg && st4_ready |=> st4_valid_reg)
        else $error("stage 3 transaction dropped on its way to stage 4");

endmodule
